// ----- hdl/gqc_pkg.sv -----
// ----------------------------------------------------------------------------
// gqc_pkg: shared types and constants of the glyph quad clipper
// Fixed-point widths, register indexes and the word types of both channels.
// ----------------------------------------------------------------------------
package gqc_pkg;

    localparam int POS_FRAC_BITS = 8;
    localparam int SH_L   = (POS_FRAC_BITS >= 8) ? POS_FRAC_BITS - 8 : 0;
    localparam int SH_R   = (POS_FRAC_BITS < 8) ? 8 - POS_FRAC_BITS : 0;
    localparam int PROD_W = 24;              // 8 x 16 bit size product
    localparam int LEN_W  = PROD_W + SH_L;   // scaled length
    localparam int CW     = LEN_W + 3;       // working coordinate width, signed
    localparam int TW     = 17;              // texture coordinate width
    localparam int QW     = TW;              // quotient bits, one per divider stage
    localparam int NUM_W  = TW + CW;         // dividend width

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 3'd4;

    typedef struct packed {
        logic signed [23:0] pen_x;
        logic signed [23:0] pen_y;
        logic signed [23:0] depth;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic [16:0]        tex_left;
        logic [16:0]        tex_right;
        logic [16:0]        tex_top;
        logic [16:0]        tex_bottom;
        logic [7:0]         char_code;
    } t_in_word;

    typedef struct packed {
        logic               drawn;
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic signed [23:0] vert_z;
        logic [16:0]        vert_u;
        logic [16:0]        vert_v;
        logic [31:0]        vert_color;
        logic               end_of_strip;
        logic signed [23:0] next_pen_x;
        logic               last;
    } t_out_word;

endpackage

// ----- hdl/gqc_div.sv -----
// ----------------------------------------------------------------------------
// gqc_div: pipelined restoring divider
// One quotient bit per stage; the quotient is known to fit in QW bits.
// ----------------------------------------------------------------------------
module gqc_div (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [gqc_pkg::NUM_W-1:0] i_num,
    input  logic [gqc_pkg::CW-1:0]    i_den,
    output logic [gqc_pkg::QW-1:0]    o_quo
);
    import gqc_pkg::*;

    // The last stage keeps only the finished quotient.
    logic [CW-1:0] r_rem [0:QW-2];
    logic [QW-1:0] r_low [0:QW-2];
    logic [QW-1:0] r_q   [0:QW-1];
    logic [CW-1:0] r_den [0:QW-2];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [CW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [CW-1:0] den_in;
        logic [CW:0]   t;
        logic          ge;
        logic [CW-1:0] n_rem;
        logic [QW-1:0] n_q;

        if (s == 0) begin : g_first
            assign rem_in = i_num[NUM_W-1:QW];
            assign low_in = i_num[QW-1:0];
            assign q_in   = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign low_in = r_low[s-1];
            assign q_in   = r_q[s-1];
            assign den_in = r_den[s-1];
        end

        always_comb begin
            t  = {rem_in, low_in[QW-1-s]};
            ge = (t >= {1'b0, den_in});
            n_rem = ge ? CW'(t - {1'b0, den_in}) : t[CW-1:0];
            n_q = q_in;
            n_q[QW-1-s] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s] <= n_q;
            end
        end

        if (s < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_low[s] <= low_in;
                    r_den[s] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

// ----- hdl/glyph_quad_clip_uv_core.sv -----
// ----------------------------------------------------------------------------
// glyph_quad_clip_uv_core: glyph quad clipper with texture interpolation
// Scales a glyph, clips it to the clip box and emits a four-vertex strip, or one skip word when nothing is drawn.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  input    | i_in_valid, o_in_ready, i_in_word        | one glyph placement
//  output   | o_out_valid, i_out_ready, o_out_word     | one vertex or skip word
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data          | register write
//
// A glyph passes four front stages (capture, scale, clip test, multiply), then
// QW divider stages and the output register. A drawn glyph leaves as four
// words, a skipped glyph as one word; the pipeline takes no new glyph until the
// last word of the current one is accepted at the single output port. Reset is
// synchronous, active low, and clears the valid bits, the beat counter and the
// configuration registers. A stall on the output freezes the whole pipeline in
// place; nothing is dropped or repeated.
module glyph_quad_clip_uv_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gqc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gqc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gqc_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gqc_pkg::t_out_word            o_out_word
);
    import gqc_pkg::*;

    typedef enum logic [1:0] {K_ZERO, K_OUTSIDE, K_DRAW} t_kind;

    // Sideband that travels beside the dividers.
    typedef struct packed {
        t_kind              kind;
        logic signed [23:0] xl;
        logic signed [23:0] xr;
        logic signed [23:0] yt;
        logic signed [23:0] yb;
        logic signed [23:0] z;
        logic signed [23:0] npx;
        logic [3:0]         clip;   // left, top, right, bottom
        logic [3:0]         neg;
        logic [TW-1:0]      u1;
        logic [TW-1:0]      u2;
        logic [TW-1:0]      v1;
        logic [TW-1:0]      v2;
    } t_side;

    function automatic logic signed [23:0] sat24(input logic signed [CW-1:0] v);
        if (v > CW'(signed'(24'sh7FFFFF)))
            return 24'sh7FFFFF;
        else if (v < CW'(signed'(-24'sh800000)))
            return -24'sh800000;
        else
            return v[23:0];
    endfunction

    function automatic logic [LEN_W-1:0] scale_len(input logic [PROD_W-1:0] p);
        return (LEN_W'(p) << SH_L) >> SH_R;
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [23:0] r_clip_l, r_clip_t, r_clip_r, r_clip_b;
    logic [31:0]        r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_l <= '0;
            r_clip_t <= '0;
            r_clip_r <= 24'sd163840;
            r_clip_b <= 24'sd122880;
            r_color  <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLIP_LEFT:   r_clip_l <= i_cfg_data[23:0];
                REG_CLIP_TOP:    r_clip_t <= i_cfg_data[23:0];
                REG_CLIP_RIGHT:  r_clip_r <= i_cfg_data[23:0];
                REG_CLIP_BOTTOM: r_clip_b <= i_cfg_data[23:0];
                REG_TEXT_COLOR:  r_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves when the output register can take a new glyph.
    logic adv;

    // ---------------- stage A: capture and size products ----------------
    logic              r_a_v;
    t_in_word          r_a_in;
    logic [PROD_W-1:0] r_a_w, r_a_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_in <= i_in_word;
            r_a_w  <= PROD_W'(i_in_word.glyph_width)  * PROD_W'(i_in_word.scale_x);
            r_a_h  <= PROD_W'(i_in_word.glyph_height) * PROD_W'(i_in_word.scale_y);
        end
    end

    // ---------------- stage B: scaling, double height, far edges ----------------
    logic [LEN_W-1:0]     b_wc, b_hc0;
    logic                 b_dbl;
    logic [CW-1:0]        b_hc;
    logic signed [CW-1:0] b_x1, b_y1;

    always_comb begin
        b_wc  = scale_len(r_a_w);
        b_hc0 = scale_len(r_a_h);
        b_dbl = (r_a_in.char_code == 8'd4) || (r_a_in.char_code == 8'd6);
        b_x1  = CW'(r_a_in.pen_x);
        b_y1  = CW'(r_a_in.pen_y);
        b_hc  = CW'(b_hc0);
        if (b_dbl) begin
            b_y1 = b_y1 - signed'(CW'(b_hc0 >> 1));
            b_hc = CW'(b_hc0) << 1;
        end
    end

    logic                 r_b_v;
    logic signed [CW-1:0] r_b_x1, r_b_x2, r_b_y1, r_b_y2;
    logic [CW-1:0]        r_b_wc, r_b_hc;
    logic                 r_b_zero;
    logic signed [23:0]   r_b_pen, r_b_z;
    logic [TW-1:0]        r_b_u1, r_b_u2, r_b_v1, r_b_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_x1   <= b_x1;
            r_b_x2   <= b_x1 + signed'(CW'(b_wc));
            r_b_y1   <= b_y1;
            r_b_y2   <= b_y1 + signed'(b_hc);
            r_b_wc   <= CW'(b_wc);
            r_b_hc   <= b_hc;
            r_b_zero <= (b_wc == '0) || (b_hc == '0);
            r_b_pen  <= r_a_in.pen_x;
            r_b_z    <= r_a_in.depth;
            r_b_u1   <= r_a_in.tex_left;
            r_b_u2   <= r_a_in.tex_right;
            r_b_v1   <= r_a_in.tex_top;
            r_b_v2   <= r_a_in.tex_bottom;
        end
    end

    // ---------------- stage C: clip test, distances, texture spans ----------------
    logic signed [CW-1:0] cl, ct, cr, cb;
    logic                 c_out;
    logic [3:0]           c_clip;
    logic signed [CW-1:0] c_d [0:3];
    logic signed [TW:0]   c_diff [0:3];
    t_side                c_side;

    always_comb begin
        cl = CW'(r_clip_l);
        ct = CW'(r_clip_t);
        cr = CW'(r_clip_r);
        cb = CW'(r_clip_b);
        c_out = (r_b_x1 >= cr) || (r_b_y1 >= cb) || (r_b_x2 <= cl) || (r_b_y2 <= ct);
        c_clip[0] = r_b_x1 < cl;
        c_clip[1] = r_b_y1 < ct;
        c_clip[2] = r_b_x2 > cr;
        c_clip[3] = r_b_y2 > cb;
        c_d[0] = cl - r_b_x1;
        c_d[1] = ct - r_b_y1;
        c_d[2] = r_b_x2 - cr;
        c_d[3] = r_b_y2 - cb;
        c_diff[0] = signed'({1'b0, r_b_u2}) - signed'({1'b0, r_b_u1});
        c_diff[1] = signed'({1'b0, r_b_v2}) - signed'({1'b0, r_b_v1});
        c_diff[2] = signed'({1'b0, r_b_u1}) - signed'({1'b0, r_b_u2});
        c_diff[3] = signed'({1'b0, r_b_v1}) - signed'({1'b0, r_b_v2});

        c_side.kind = r_b_zero ? K_ZERO : (c_out ? K_OUTSIDE : K_DRAW);
        c_side.xl   = c_clip[0] ? r_clip_l : r_b_x1[23:0];
        c_side.yt   = c_clip[1] ? r_clip_t : r_b_y1[23:0];
        c_side.xr   = c_clip[2] ? r_clip_r : r_b_x2[23:0];
        c_side.yb   = c_clip[3] ? r_clip_b : r_b_y2[23:0];
        c_side.z    = r_b_z;
        if (r_b_zero)
            c_side.npx = r_b_pen;
        else if (c_out)
            c_side.npx = sat24(r_b_x2);
        else
            c_side.npx = sat24(c_clip[2] ? cr : r_b_x2);
        c_side.clip = c_clip;
        for (int k = 0; k < 4; k++) begin
            c_side.neg[k] = c_diff[k][TW];
        end
        c_side.u1 = r_b_u1;
        c_side.u2 = r_b_u2;
        c_side.v1 = r_b_v1;
        c_side.v2 = r_b_v2;
    end

    logic          r_c_v;
    t_side         r_c_side;
    logic [TW-1:0] r_c_mag [0:3];
    logic [CW-1:0] r_c_d   [0:3];
    logic [CW-1:0] r_c_wc, r_c_hc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_side <= c_side;
            r_c_wc   <= r_b_wc;
            r_c_hc   <= r_b_hc;
            for (int k = 0; k < 4; k++) begin
                r_c_mag[k] <= c_diff[k][TW] ? TW'(-c_diff[k]) : c_diff[k][TW-1:0];
                // Lanes of sides that are not clipped divide zero.
                r_c_d[k]   <= c_clip[k] ? c_d[k] : '0;
            end
        end
    end

    // ---------------- stage D: span times clipped distance ----------------
    logic             r_d_v;
    t_side            r_d_side;
    logic [NUM_W-1:0] r_d_num [0:3];
    logic [CW-1:0]    r_d_den [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (adv) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_side <= r_c_side;
            for (int k = 0; k < 4; k++) begin
                r_d_num[k] <= NUM_W'(r_c_mag[k]) * NUM_W'(r_c_d[k]);
                r_d_den[k] <= (k == 0 || k == 2) ? r_c_wc : r_c_hc;
            end
        end
    end

    // ---------------- divider lanes ----------------
    logic [QW-1:0] quo [0:3];

    for (genvar k = 0; k < 4; k++) begin : g_lane
        gqc_div u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (r_d_num[k]),
            .i_den (r_d_den[k]),
            .o_quo (quo[k])
        );
    end

    logic  r_sd_v    [0:QW-1];
    t_side r_sd_side [0:QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QW; s++) begin
                r_sd_v[s] <= 1'b0;
            end
        end else if (adv) begin
            r_sd_v[0] <= r_d_v;
            for (int s = 1; s < QW; s++) begin
                r_sd_v[s] <= r_sd_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd_side[0] <= r_d_side;
            for (int s = 1; s < QW; s++) begin
                r_sd_side[s] <= r_sd_side[s-1];
            end
        end
    end

    // ---------------- stage E: interpolated texture edges ----------------
    t_side         e_side;
    logic [TW-1:0] e_near [0:3];
    logic [TW-1:0] e_res  [0:3];

    always_comb begin
        e_side    = r_sd_side[QW-1];
        e_near[0] = e_side.u1;
        e_near[1] = e_side.v1;
        e_near[2] = e_side.u2;
        e_near[3] = e_side.v2;
        for (int k = 0; k < 4; k++) begin
            if (!e_side.clip[k])
                e_res[k] = e_near[k];
            else if (e_side.neg[k])
                e_res[k] = e_near[k] - quo[k];
            else
                e_res[k] = e_near[k] + quo[k];
        end
    end

    // ---------------- output register and strip sequencer ----------------
    logic          r_o_v;
    logic [1:0]    r_beat;
    t_side         r_o_side;
    logic [TW-1:0] r_o_res [0:3];
    logic          last_beat;

    assign last_beat = (r_o_side.kind != K_DRAW) || (r_beat == 2'd3);
    assign adv        = !r_o_v || (i_out_ready && last_beat);
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_beat <= '0;
        end else if (adv) begin
            r_o_v  <= r_sd_v[QW-1];
            r_beat <= '0;
        end else if (i_out_ready) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_side <= e_side;
            for (int k = 0; k < 4; k++) begin
                r_o_res[k] <= e_res[k];
            end
        end
    end

    // Strip order: left-bottom, left-top, right-bottom, right-top.
    always_comb begin
        o_out_word            = '0;
        o_out_word.next_pen_x = r_o_side.npx;
        o_out_word.last       = last_beat;
        if (r_o_side.kind == K_DRAW) begin
            o_out_word.drawn        = 1'b1;
            o_out_word.vert_z       = r_o_side.z;
            o_out_word.vert_color   = r_color;
            o_out_word.end_of_strip = (r_beat == 2'd3);
            o_out_word.vert_x       = r_beat[1] ? r_o_side.xr : r_o_side.xl;
            o_out_word.vert_u       = r_beat[1] ? r_o_res[2] : r_o_res[0];
            o_out_word.vert_y       = r_beat[0] ? r_o_side.yt : r_o_side.yb;
            o_out_word.vert_v       = r_beat[0] ? r_o_res[1] : r_o_res[3];
        end
    end

    assign o_out_valid = r_o_v;

endmodule

// ----- dv/tb_glyph_quad_clip_uv_core.sv -----
// ----------------------------------------------------------------------------
// tb_glyph_quad_clip_uv_core: self-checking testbench of the glyph clipper
// Drives directed and random glyph placements through several clip boxes and
// colors, predicts every vertex or skip word, and checks them in order.
// ----------------------------------------------------------------------------
module tb_glyph_quad_clip_uv_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gqc_pkg::*;

    localparam int LATENCY   = QW + 12;
    localparam int N_RANDOM  = 240;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;

    glyph_quad_clip_uv_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The testbench's own copy of the clip box and the vertex color.
    longint    box_left, box_top, box_right, box_bottom;
    logic [31:0] vert_color_reg;

    t_out_word vertex_queue[$];
    int        mismatch_count = 0;
    bit        hold_off = 1'b0;

    function automatic longint sext24(logic [23:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [23:0] sat24(longint v);
        if (v > 64'sd8388607)  v = 8388607;
        if (v < -64'sd8388608) v = -8388608;
        return v[23:0];
    endfunction

    // Texture coordinate of a clipped edge, quotient truncated toward zero.
    function automatic longint clip_tex(longint near_t, longint far_t, longint d,
                                        longint size);
        return near_t + ((far_t - near_t) * d) / size;
    endfunction

    function automatic t_out_word make_vertex(longint x, longint y, logic [23:0] z,
                                              longint u, longint v, bit eos,
                                              longint npx);
        t_out_word w;
        w.drawn        = 1'b1;
        w.vert_x       = x[23:0];
        w.vert_y       = y[23:0];
        w.vert_z       = z;
        w.vert_u       = u[16:0];
        w.vert_v       = v[16:0];
        w.vert_color   = vert_color_reg;
        w.end_of_strip = eos;
        w.next_pen_x   = sat24(npx);
        w.last         = eos;
        return w;
    endfunction

    // Works out the vertex words of one glyph and queues them.
    task automatic predict_glyph(t_in_word g);
        longint x1, y1, x2, y2, wc, hc, u1, u2, v1, v2, nu1, nu2, nv1, nv2;
        t_out_word skip;
        x1 = sext24(g.pen_x);
        y1 = sext24(g.pen_y);
        wc = longint'(g.glyph_width) * longint'(g.scale_x);
        hc = longint'(g.glyph_height) * longint'(g.scale_y);
        if (POS_FRAC_BITS >= 8) begin
            wc = wc <<< SH_L;
            hc = hc <<< SH_L;
        end else begin
            wc = wc >>> SH_R;
            hc = hc >>> SH_R;
        end
        u1 = g.tex_left;
        u2 = g.tex_right;
        v1 = g.tex_top;
        v2 = g.tex_bottom;
        if (g.char_code == 8'd4 || g.char_code == 8'd6) begin
            y1 = y1 - hc / 2;
            hc = hc * 2;
        end
        skip = '0;
        skip.last = 1'b1;
        if (hc <= 0 || wc <= 0) begin
            skip.next_pen_x = sat24(x1);
            vertex_queue.push_back(skip);
            return;
        end
        x2 = x1 + wc;
        y2 = y1 + hc;
        if (x1 >= box_right || y1 >= box_bottom || x2 <= box_left || y2 <= box_top) begin
            skip.next_pen_x = sat24(x2);
            vertex_queue.push_back(skip);
            return;
        end
        nu1 = u1; nu2 = u2; nv1 = v1; nv2 = v2;
        if (x1 < box_left) begin
            nu1 = clip_tex(u1, u2, box_left - x1, wc);
            x1 = box_left;
        end
        if (y1 < box_top) begin
            nv1 = clip_tex(v1, v2, box_top - y1, hc);
            y1 = box_top;
        end
        if (x2 > box_right) begin
            nu2 = clip_tex(u2, u1, x2 - box_right, wc);
            x2 = box_right;
        end
        if (y2 > box_bottom) begin
            nv2 = clip_tex(v2, v1, y2 - box_bottom, hc);
            y2 = box_bottom;
        end
        vertex_queue.push_back(make_vertex(x1, y2, g.depth, nu1, nv2, 1'b0, x2));
        vertex_queue.push_back(make_vertex(x1, y1, g.depth, nu1, nv1, 1'b0, x2));
        vertex_queue.push_back(make_vertex(x2, y2, g.depth, nu2, nv2, 1'b0, x2));
        vertex_queue.push_back(make_vertex(x2, y1, g.depth, nu2, nv1, 1'b1, x2));
    endtask

    // Writes one register at a falling edge and mirrors it in the predictor.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_CLIP_LEFT:   box_left = sext24(data[23:0]);
            REG_CLIP_TOP:    box_top = sext24(data[23:0]);
            REG_CLIP_RIGHT:  box_right = sext24(data[23:0]);
            REG_CLIP_BOTTOM: box_bottom = sext24(data[23:0]);
            REG_TEXT_COLOR:  vert_color_reg = data;
            default: ;
        endcase
    endtask

    task automatic set_box(logic [23:0] l, logic [23:0] t, logic [23:0] r,
                           logic [23:0] b, logic [31:0] c);
        write_reg(REG_CLIP_LEFT, {8'h0, l});
        write_reg(REG_CLIP_TOP, {8'h0, t});
        write_reg(REG_CLIP_RIGHT, {8'h0, r});
        write_reg(REG_CLIP_BOTTOM, {8'h0, b});
        write_reg(REG_TEXT_COLOR, c);
    endtask

    // Offers one word after a random gap and waits for its acceptance.
    // Valid stays high across a zero gap, so words can follow back to back.
    // Prediction happens at the accepting edge, with the box then in force.
    task automatic send_glyph(t_in_word g);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= g;
        do @(posedge i_clk); while (!o_in_ready);
        predict_glyph(g);
    endtask

    // Takes valid down after the last word of a run.
    task automatic stop_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (vertex_queue.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_in_word random_glyph();
        t_in_word g;
        g.pen_x = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                              : 24'($signed($urandom_range(0, 50000)) - 10000);
        g.pen_y = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                              : 24'($signed($urandom_range(0, 40000)) - 10000);
        g.depth = 24'($urandom);
        case ($urandom_range(0, 3))
            0: g.scale_x = 16'($urandom);
            default: g.scale_x = 16'($urandom_range(64, 1024));
        endcase
        case ($urandom_range(0, 3))
            0: g.scale_y = 16'($urandom);
            default: g.scale_y = 16'($urandom_range(64, 1024));
        endcase
        g.glyph_width  = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom);
        g.glyph_height = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom);
        g.tex_left   = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        g.tex_right  = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        g.tex_top    = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        g.tex_bottom = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        g.char_code  = ($urandom_range(0, 3) == 0) ? 8'(4 + 2 * $urandom_range(0, 1))
                                                   : 8'($urandom);
        return g;
    endfunction

    // Directed glyphs. A row with has_word set also carries the word typed
    // in by hand; every row is checked against the predictor as well.
    typedef struct {
        t_in_word  glyph;
        bit        has_word;
        t_out_word word;
    } t_glyph_row;

    t_glyph_row glyph_table[$];

    function automatic t_in_word mk(int px, int py, int pz, int sx, int sy, int gw,
                                    int gh, int ul, int ur, int vt, int vb, int code);
        t_in_word g;
        g.pen_x = 24'(px); g.pen_y = 24'(py); g.depth = 24'(pz);
        g.scale_x = 16'(sx); g.scale_y = 16'(sy);
        g.glyph_width = 8'(gw); g.glyph_height = 8'(gh);
        g.tex_left = 17'(ul); g.tex_right = 17'(ur);
        g.tex_top = 17'(vt); g.tex_bottom = 17'(vb);
        g.char_code = 8'(code);
        return g;
    endfunction

    function automatic t_out_word skip_word(int npx);
        t_out_word w;
        w = '0;
        w.last = 1'b1;
        w.next_pen_x = 24'(npx);
        return w;
    endfunction

    task automatic add_row(t_in_word g, bit has_word = 1'b0, t_out_word w = '0);
        t_glyph_row row;
        row.glyph = g;
        row.has_word = has_word;
        row.word = w;
        glyph_table.push_back(row);
    endtask

    task automatic build_table();
        // Zero width and zero height give one skip word with the pen unchanged.
        add_row(mk(1234, 50, 7, 256, 256, 0, 10, 0, 65536, 0, 65536, 65), 1'b1,
                skip_word(1234));
        add_row(mk(-8388608, 50, 7, 256, 256, 10, 0, 0, 65536, 0, 65536, 65), 1'b1,
                skip_word(-8388608));
        add_row(mk(100, 100, 0, 0, 256, 10, 10, 0, 0, 0, 0, 4), 1'b1, skip_word(100));
        // Entirely right of the box, and a right edge that saturates.
        add_row(mk(200000, 100, 0, 256, 256, 10, 10, 0, 1, 2, 3, 0), 1'b1,
                skip_word(200000 + 2560));
        add_row(mk(8388607, 0, 0, 65535, 65535, 255, 255, 0, 65536, 0, 65536, 255), 1'b1,
                skip_word(8388607));
        // Entirely left, above and below.
        add_row(mk(-3000, 100, 0, 256, 256, 10, 10, 0, 1, 2, 3, 0), 1'b1, skip_word(-440));
        add_row(mk(100, -5000, 0, 256, 256, 10, 10, 0, 1, 2, 3, 0));
        add_row(mk(100, 130000, 0, 256, 256, 10, 10, 0, 1, 2, 3, 0));
        // Fully inside, then clipped on each side in turn, and on all of them.
        add_row(mk(1000, 1000, -8388608, 256, 256, 16, 16, 0, 65536, 0, 65536, 65));
        add_row(mk(-1000, 1000, 8388607, 256, 256, 16, 16, 0, 65536, 0, 65536, 65));
        add_row(mk(1000, -1000, 5, 256, 256, 16, 16, 65536, 0, 65536, 0, 65));
        add_row(mk(162000, 1000, 5, 256, 256, 16, 16, 100, 60000, 7, 9000, 65));
        add_row(mk(1000, 121000, 5, 256, 256, 16, 16, 100, 60000, 7, 9000, 65));
        add_row(mk(-20000, -20000, 5, 65535, 65535, 255, 255, 0, 65536, 65536, 0, 1));
        // Double height codes 4 and 6, each with its raised top clipped, then plain code 5.
        add_row(mk(2000, 2000, 5, 256, 256, 16, 16, 0, 65536, 0, 65536, 4));
        add_row(mk(2000, 1000, 5, 300, 333, 17, 15, 0, 65536, 0, 65536, 6));
        add_row(mk(2000, 1000, 5, 300, 333, 17, 15, 0, 65536, 0, 65536, 5));
        // Texture values above 65536.
        add_row(mk(-500, -500, 5, 256, 256, 8, 8, 131071, 131071, 131071, 131071, 0));
        add_row(mk(-500, -500, 5, 1, 1, 255, 255, 131071, 0, 0, 131071, 255));
        // Touching the box edges exactly.
        add_row(mk(163840, 100, 5, 256, 256, 4, 4, 0, 1, 2, 3, 0));
        add_row(mk(-1024, 100, 5, 256, 256, 4, 4, 0, 1, 2, 3, 0));
    endtask

    // Receiver: random stalls, plus a long hold-off requested by the sender.
    initial begin : out_stall
        int gap;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                gap = $urandom_range(0, 12);
                if (gap != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
        end
    end

    // Checks every accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vertex_queue.size() == 0) begin
                $display("%0t: unexpected word %p", $time, o_out_word);
                mismatch_count++;
            end else begin
                exp_w = vertex_queue.pop_front();
                if (o_out_word !== exp_w) begin
                    $display("%0t: word mismatch expected %p actual %p",
                             $time, exp_w, o_out_word);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #4000000;
        $display("glyph_quad_clip_uv_core regression: fail");
        $finish;
    end

    initial begin : main
        t_glyph_row row;
        box_left = 0;
        box_top = 0;
        box_right = 163840;
        box_bottom = 122880;
        vert_color_reg = 32'hFFFF_FFFF;
        build_table();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows run with the reset box.
        foreach (glyph_table[k]) begin
            row = glyph_table[k];
            send_glyph(row.glyph);
            if (row.has_word && vertex_queue[$] !== row.word) begin
                $display("%0t: table row %0d expected %p predicted %p",
                         $time, k, row.word, vertex_queue[$]);
                mismatch_count++;
            end
        end
        stop_input();
        drain();

        // Random phases, each under its own box and color.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_box(24'd0, 24'd0, 24'd163840, 24'd122880, 32'h0000_0000);
                1: set_box(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFF_FFFF);
                2: set_box(24'd5000, 24'd3000, 24'd20000, 24'd15000, 32'h8040_20C1);
                3: set_box(24'd20000, 24'd15000, 24'd5000, 24'd3000, 32'($urandom));
                4: set_box(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                           32'($urandom));
                default: set_box(-24'sd2000, -24'sd2000, 24'd30000, 24'd30000, 32'($urandom));
            endcase
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                // Partway through the first phase, starve the output side.
                if (phase == 0 && n == 10) hold_off = 1'b1;
                send_glyph(random_glyph());
            end
            stop_input();
            drain();
        end

        if (mismatch_count == 0 && vertex_queue.size() == 0) begin
            $display("glyph_quad_clip_uv_core regression: pass");
        end else begin
            $display("glyph_quad_clip_uv_core regression: fail");
        end
        $finish;
    end

endmodule
